FILE: rtl/deadline_timer_queue_assert.svh
// Assertion macros for the deadline timer queue.
// Used by the top level only; has no dependencies.
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define DTQ_ASSERT_SAME(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define DTQ_ASSERT_NEXT(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// Used by dtq_cell, deadline_timer_queue and the testbench; depends on nothing.
package dtq_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEPTH_DEFAULT     = 16;
  localparam int TIME_BITS_DEFAULT = 32;

  // Fixed field widths.
  localparam int FIELD_TIME_W = 32;
  localparam int TASK_W       = 16;
  localparam int PEND_W       = 5;
  localparam int KIND_W       = 2;

  // Item modes.
  localparam logic MODE_SCHEDULE = 1'b0;
  localparam logic MODE_TICK     = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOTHING = 2'd2;

  // One input item.
  typedef struct packed {
    logic                    mode;
    logic [FIELD_TIME_W-1:0] due_time;
    logic [TASK_W-1:0]       task_id;
    logic [FIELD_TIME_W-1:0] now_time;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] fired_task;
    logic              accepted;
    logic              last;
    logic [PEND_W-1:0] pending_count;
  } res_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic shift;  // take the entry of the next cell up
    logic write;  // the cell at the write position takes the write data
  } cell_ctl_t;

endpackage

FILE: rtl/dtq_cell.sv
// One cell of the timer row: holds one due time and one task id.
// Depends on dtq_pkg for the control struct and the task width.
module dtq_cell #(
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEFAULT,
  parameter int POS_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                      clk,
  input  dtq_pkg::cell_ctl_t        ctl,
  input  logic [POS_W-1:0]          pos,
  input  logic [TIME_BITS-1:0]      wr_due,
  input  logic [dtq_pkg::TASK_W-1:0] wr_task,
  input  logic [TIME_BITS-1:0]      nb_due,
  input  logic [dtq_pkg::TASK_W-1:0] nb_task,
  output logic [TIME_BITS-1:0]      due,
  output logic [dtq_pkg::TASK_W-1:0] task_id
);

  logic hit;

  // This cell is the target of a write when the position names it.
  assign hit = ctl.write && (pos == POS_W'(INDEX));

  // A write wins over the shift toward the head.
  always_ff @(posedge clk) begin
    if (hit) begin
      due     <= wr_due;
      task_id <= wr_task;
    end else if (ctl.shift) begin
      due     <= nb_due;
      task_id <= nb_task;
    end
  end

endmodule

FILE: rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: control and the row of cells.
// Depends on dtq_pkg, dtq_cell and deadline_timer_queue_assert.svh.
`include "deadline_timer_queue_assert.svh"

// A schedule item's acknowledgement appears on the next cycle and busy
// stays low, so schedule items may follow every cycle. A tick item keeps
// busy high while the row rotates the pending entries (at most DEPTH) one
// entry per cycle past the head cell, where the one due-time compare decides
// whether it fires or goes back to the tail; a closing state follows. The
// final result of a tick appears in the same cycle in which busy falls.
// Every result is shown for exactly one cycle with result_valid high and
// must be taken then, since there is no stall input.
module deadline_timer_queue #(
  parameter int DEPTH     = dtq_pkg::DEPTH_DEFAULT,
  parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dtq_pkg::req_t request,
  output logic          result_valid,
  output dtq_pkg::res_t result
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PW     = dtq_pkg::PEND_W;
  localparam int TW     = dtq_pkg::TASK_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]           state;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     steps;
  logic [TIME_BITS-1:0] now;
  logic                 held_valid;
  logic [TW-1:0]        held_task;
  logic [CNT_W-1:0]     held_pend;

  logic [TIME_BITS-1:0] cell_due  [DEPTH];
  logic [TW-1:0]        cell_task [DEPTH];

  dtq_pkg::cell_ctl_t   ctl;
  logic [CNT_W-1:0]     wr_pos;
  logic [TIME_BITS-1:0] wr_due;
  logic [TW-1:0]        wr_task;
  logic                 accept;
  logic                 room;
  logic                 fire;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign room   = (count < CNT_W'(DEPTH));
  assign fire   = (cell_due[0] <= now);

  // Row control: append on schedule, rotate on tick, keeping entries at the tail.
  always_comb begin
    ctl.shift = (state == ST_SCAN);
    ctl.write = 1'b0;
    wr_pos    = count;
    wr_due    = TIME_BITS'(request.due_time);
    wr_task   = request.task_id;
    if (state == ST_SCAN) begin
      ctl.write = !fire;
      wr_pos    = count - CNT_W'(1);
      wr_due    = cell_due[0];
      wr_task   = cell_task[0];
    end else if (accept && (request.mode == dtq_pkg::MODE_SCHEDULE)) begin
      ctl.write = room;
    end
  end

  // The row of cells, each handing its entry toward the head.
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [TIME_BITS-1:0] nb_due;
      logic [TW-1:0]        nb_task;
      if (gi < DEPTH - 1) begin : g_mid
        assign nb_due  = cell_due[gi+1];
        assign nb_task = cell_task[gi+1];
      end else begin : g_tail
        assign nb_due  = '0;
        assign nb_task = '0;
      end
      dtq_cell #(
        .TIME_BITS (TIME_BITS),
        .POS_W     (CNT_W),
        .INDEX     (gi)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .pos     (wr_pos),
        .wr_due  (wr_due),
        .wr_task (wr_task),
        .nb_due  (nb_due),
        .nb_task (nb_task),
        .due     (cell_due[gi]),
        .task_id (cell_task[gi])
      );
    end
  endgenerate

  // Sequencer: acknowledges schedules, scans on ticks and emits results.
  // A fired entry is held back so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      steps        <= '0;
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (request.mode == dtq_pkg::MODE_SCHEDULE) begin
              result_valid         <= 1'b1;
              result.kind          <= dtq_pkg::KIND_ACK;
              result.fired_task    <= '0;
              result.accepted      <= room;
              result.last          <= 1'b1;
              if (room) begin
                count                <= count + CNT_W'(1);
                result.pending_count <= PW'(count + CNT_W'(1));
              end else begin
                result.pending_count <= PW'(count);
              end
            end else begin
              now        <= TIME_BITS'(request.now_time);
              held_valid <= 1'b0;
              steps      <= count;
              state      <= (count == '0) ? ST_FINISH : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fire) begin
            count      <= count - CNT_W'(1);
            held_valid <= 1'b1;
            held_task  <= cell_task[0];
            held_pend  <= count - CNT_W'(1);
            if (held_valid) begin
              result_valid         <= 1'b1;
              result.kind          <= dtq_pkg::KIND_FIRED;
              result.fired_task    <= held_task;
              result.accepted      <= 1'b0;
              result.last          <= 1'b0;
              result.pending_count <= PW'(held_pend);
            end
          end
          steps <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          result_valid    <= 1'b1;
          result.accepted <= 1'b0;
          result.last     <= 1'b1;
          if (held_valid) begin
            result.kind          <= dtq_pkg::KIND_FIRED;
            result.fired_task    <= held_task;
            result.pending_count <= PW'(held_pend);
          end else begin
            result.kind          <= dtq_pkg::KIND_NOTHING;
            result.fired_task    <= '0;
            result.pending_count <= PW'(count);
          end
          held_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Conditions watched by the checks below.
  logic out_last;
  logic out_single;
  logic tick_take;
  assign out_last   = result_valid && result.last;
  assign out_single = result_valid && (result.kind != dtq_pkg::KIND_FIRED);
  assign tick_take  = accept && (request.mode == dtq_pkg::MODE_TICK);

  // The pending count never passes the table size.
  `DTQ_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count above depth")

  // The closing result of an item reports the table as it now stands.
  `DTQ_ASSERT_SAME(a_last_count, clk, rst, out_last, result.pending_count == PW'(count), "bad count")

  // A tick taken in makes the block busy on the next cycle.
  `DTQ_ASSERT_NEXT(a_tick_busy, clk, rst, tick_take, busy, "tick did not start a scan")

  // Acknowledgements and empty results are always the only result of their item.
  `DTQ_ASSERT_SAME(a_single_last, clk, rst, out_single, result.last, "single result not last")

endmodule

FILE: tb/dtq_result_checker.sv
// Result checker for the deadline timer queue: predicts every result and compares.
// Depends on dtq_pkg; watches the item and result channels of the top level.
module dtq_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  dtq_pkg::req_t request,
  input  logic          result_valid,
  input  dtq_pkg::res_t result,
  output int unsigned   mismatches,
  output int unsigned   awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = dtq_pkg::DEPTH_DEFAULT;
  localparam int TBITS = dtq_pkg::TIME_BITS_DEFAULT;

  // Predicted timer table, kept in insertion order.
  logic [TBITS-1:0]           model_due  [SLOTS];
  logic [dtq_pkg::TASK_W-1:0] model_task [SLOTS];
  int unsigned                model_count;

  // Results still to come, oldest first.
  dtq_pkg::res_t awaited_results [$];
  int unsigned   fail_count;

  // Appends one predicted result at the back of the list.
  function automatic void add_awaited(dtq_pkg::res_t e);
    awaited_results = {awaited_results, e};
  endfunction

  // Works out the results of one accepted item and updates the timer table.
  function automatic void apply_item(dtq_pkg::req_t r);
    dtq_pkg::res_t e;
    int unsigned   kept;
    int unsigned   remaining;
    int unsigned   due_now;
    int unsigned   fired;
    if (r.mode == dtq_pkg::MODE_SCHEDULE) begin
      e      = '0;
      e.kind = dtq_pkg::KIND_ACK;
      e.last = 1'b1;
      if (model_count < SLOTS) begin
        model_due[model_count]  = r.due_time[TBITS-1:0];
        model_task[model_count] = r.task_id;
        model_count++;
        e.accepted = 1'b1;
      end
      e.pending_count = dtq_pkg::PEND_W'(model_count);
      add_awaited(e);
    end else begin
      // Count the due entries first so the final one can be marked.
      due_now = 0;
      for (int i = 0; i < model_count; i++) begin
        if (model_due[i] <= r.now_time[TBITS-1:0]) due_now++;
      end
      kept      = 0;
      remaining = model_count;
      fired     = 0;
      for (int i = 0; i < model_count; i++) begin
        if (model_due[i] <= r.now_time[TBITS-1:0]) begin
          remaining--;
          e               = '0;
          e.kind          = dtq_pkg::KIND_FIRED;
          e.fired_task    = model_task[i];
          e.pending_count = dtq_pkg::PEND_W'(remaining);
          e.last          = (fired == due_now - 1);
          add_awaited(e);
          fired++;
        end else begin
          model_due[kept]  = model_due[i];
          model_task[kept] = model_task[i];
          kept++;
        end
      end
      model_count = kept;
      if (fired == 0) begin
        e               = '0;
        e.kind          = dtq_pkg::KIND_NOTHING;
        e.last          = 1'b1;
        e.pending_count = dtq_pkg::PEND_W'(model_count);
        add_awaited(e);
      end
    end
  endfunction

  // Counts a failure; only the first ten are described.
  function automatic void report(string what, dtq_pkg::res_t want, dtq_pkg::res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $write("%0t: %s: expected kind=%0d task=%h acc=%b last=%b pend=%0d, ",
             $time, what, want.kind, want.fired_task, want.accepted, want.last,
             want.pending_count);
      $display("got kind=%0d task=%h acc=%b last=%b pend=%0d",
               got.kind, got.fired_task, got.accepted, got.last, got.pending_count);
    end
  endfunction

  // Compare the result first, then predict for an item taken at the same edge.
  always @(posedge clk) begin
    dtq_pkg::res_t want;
    logic          same;
    if (rst) begin
      model_count = 0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        if (awaited_results.size() == 0) begin
          report("result with nothing awaited", '0, result);
        end else begin
          want = awaited_results.pop_front();
          same = (result.kind == want.kind) && (result.fired_task == want.fired_task) &&
                 (result.accepted == want.accepted) && (result.last == want.last) &&
                 (result.pending_count == want.pending_count);
          if (!same) report("result mismatch", want, result);
        end
      end
      if (start && !busy) apply_item(request);
    end
    mismatches <= fail_count;
    awaited    <= awaited_results.size();
  end

endmodule

FILE: tb/tb.sv
// Top of the deadline timer queue testbench: clock, reset, items and the verdict.
// Depends on dtq_pkg, deadline_timer_queue and dtq_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_ITEMS = 330;

  logic          clk;
  logic          rst     = 1'b1;
  logic          start   = 1'b0;
  dtq_pkg::req_t request = '0;
  logic          busy;
  logic          result_valid;
  dtq_pkg::res_t result;
  int unsigned   mismatches;
  int unsigned   awaited;

  int unsigned      sent = 0;
  logic [31:0]      base_tick;

  deadline_timer_queue uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  dtq_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .mismatches   (mismatches),
    .awaited      (awaited)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // Builds a schedule item; the unused time field gets random bits.
  function automatic dtq_pkg::req_t schedule_item(logic [31:0] due, logic [15:0] id);
    dtq_pkg::req_t r;
    r.mode     = dtq_pkg::MODE_SCHEDULE;
    r.due_time = due;
    r.task_id  = id;
    r.now_time = $urandom();
    return r;
  endfunction

  // Builds a tick item; the unused schedule fields get random bits.
  function automatic dtq_pkg::req_t tick_item(logic [31:0] now);
    dtq_pkg::req_t r;
    r.mode     = dtq_pkg::MODE_TICK;
    r.due_time = $urandom();
    r.task_id  = 16'($urandom_range(0, 65535));
    r.now_time = now;
    return r;
  endfunction

  // Offers one item and returns once it is accepted and busy is low. The idle share
  // moves from light to heavy to none over the run; each idle cycle is drawn
  // on its own so that the share counts cycles.
  task automatic send(dtq_pkg::req_t r);
    int unsigned idle_pct;
    idle_pct = (sent < TOTAL_ITEMS / 3) ? 22 : (sent < 2 * TOTAL_ITEMS / 3) ? 75 : 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    dtq_pkg::req_t noise;
    int unsigned   pick;
    int unsigned   drain_wait;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ticks on an empty table give nothing due.
    send(tick_item(32'h0000_0000));
    send(tick_item(32'hFFFF_FFFF));
    // Extreme due times and task ids, fired one at a time.
    send(schedule_item(32'h0000_0000, 16'h0000));
    send(schedule_item(32'hFFFF_FFFF, 16'hFFFF));
    send(tick_item(32'h0000_0000));
    send(tick_item(32'hFFFF_FFFE));
    send(tick_item(32'hFFFF_FFFF));
    // Fill the table with early and late entries interleaved, then overflow it.
    for (int i = 0; i < dtq_pkg::DEPTH_DEFAULT; i++) begin
      send(schedule_item((i % 2 == 0) ? 32'd100 + i : 32'h8000_0000 + i, 16'(16'h5A00 + i)));
    end
    send(schedule_item(32'd5, 16'hBEEF));
    // Fire the early half out of the middle, then the rest.
    send(tick_item(32'd200));
    send(tick_item(32'hFFFF_FFFF));

    // Random part: mostly a steadily advancing time base with near deadlines.
    base_tick = $urandom_range(0, 1000);
    while (sent < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        noise.mode     = logic'($urandom_range(1));
        noise.due_time = $urandom();
        noise.task_id  = 16'($urandom_range(0, 65535));
        noise.now_time = $urandom();
        send(noise);
      end else if (pick < 11) begin
        send(tick_item(32'hFFFF_FFFF));
      end else if (pick < 16) begin
        // A burst that fills the table and often overflows it.
        repeat ($urandom_range(12, 18)) begin
          send(schedule_item(base_tick + $urandom_range(0, 60), 16'($urandom_range(0, 65535))));
        end
      end else if (pick < 18) begin
        base_tick = $urandom();
      end else if (pick < 60) begin
        send(schedule_item(base_tick + $urandom_range(0, 60), 16'($urandom_range(0, 65535))));
      end else begin
        base_tick = base_tick + $urandom_range(0, 24);
        send(tick_item(base_tick));
      end
    end
    start <= 1'b0;

    // Let every awaited result arrive, then keep watching for strays.
    drain_wait = 0;
    while (awaited != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (40) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: deadline_timer_queue.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_cell.sv
rtl/deadline_timer_queue.sv
tb/dtq_result_checker.sv
tb/tb.sv
